// ===== src/assert_macros.svh =====
// Assertion macros shared by the lexer RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/csl_pkg.sv =====
// Package for the C subset lexer: token codes, token record and lookup functions.
// No dependencies.
package csl_pkg;

  localparam int MAX_NAME_CHARS_DEF = 8;
  localparam int MAX_VARIABLES_DEF  = 31;
  localparam int VCNT_W             = 5;

  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_OP      = 3'd1;
  localparam logic [2:0] KIND_FUNC    = 3'd2;
  localparam logic [2:0] KIND_VAR     = 3'd3;
  localparam logic [2:0] KIND_NUM     = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [4:0] SYM_KW_BASE = 5'd5;
  localparam logic [4:0] SYM_LBRACE  = 5'd9;
  localparam logic [4:0] SYM_RBRACE  = 5'd10;
  localparam logic [4:0] SYM_NONE    = 5'd0;

  // keyword spellings packed first character in the low byte
  localparam logic [63:0] KW_WORDS [8] = '{
    64'h0000_0000_0000_6669,
    64'h0000_0000_0072_6f66,
    64'h0000_0065_6c69_6877,
    64'h0000_6e72_7574_6572,
    64'h0000_0000_0000_007b,
    64'h0000_0000_0000_007d,
    64'h0000_006b_6165_7262,
    64'h6575_6e69_746e_6f63
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  code;
    logic [63:0] name;
    logic [3:0]  len;
    logic [31:0] num;
    logic [7:0]  off;
    logic [31:0] pos;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic tok_t mk_tok(input logic [2:0] kind, input logic [4:0] code,
                                  input logic [63:0] name, input logic [3:0] len,
                                  input logic [31:0] num, input logic [7:0] off,
                                  input logic [31:0] pos);
    tok_t t;
    t.kind = kind; t.code = code; t.name = name; t.len = len;
    t.num = num;   t.off = off;   t.pos = pos;
    return t;
  endfunction

  // single operator token, or an error token when the byte is no operator
  function automatic tok_t single_tok(input logic [7:0] c, input logic [31:0] pos);
    logic [4:0] code;
    logic       hit;
    hit  = 1'b1;
    code = SYM_NONE;
    case (c)
      "+": code = 5'd13;
      "-": code = 5'd14;
      "*": code = 5'd15;
      "/": code = 5'd16;
      "%": code = 5'd17;
      "&": code = 5'd18;
      "|": code = 5'd19;
      "^": code = 5'd20;
      "(": code = 5'd21;
      ")": code = 5'd22;
      "<": code = 5'd23;
      ">": code = 5'd24;
      ";": code = 5'd25;
      "=": code = 5'd26;
      default: hit = 1'b0;
    endcase
    if (hit) return mk_tok(KIND_OP, code, 64'd0, 4'd0, 32'd0, 8'd0, pos);
    return mk_tok(KIND_ERROR, SYM_NONE, 64'd0, 4'd0, 32'd0, 8'd0, pos);
  endfunction

  // {hit, index} of a two-character operator
  function automatic logic [3:0] two_idx(input logic [7:0] a, input logic [7:0] b);
    if (a == "=" && b == "=") return 4'b1_000;
    if (a == "!" && b == "=") return 4'b1_001;
    if (a == "<" && b == "=") return 4'b1_010;
    if (a == ">" && b == "=") return 4'b1_011;
    if (a == "&" && b == "&") return 4'b1_100;
    return 4'b0_000;
  endfunction

endpackage

// ===== src/csl_if.sv =====
// Valid/ready channel interfaces for the lexer: source bytes in, tokens out.
// No dependencies.
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       end_of_source;
  modport source (output valid, source_char, end_of_source, input ready);
  modport sink   (input valid, source_char, end_of_source, output ready);
endinterface

interface csl_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         token_kind;
  logic [4:0]         symbol_code;
  logic [63:0]        name_chars;
  logic [3:0]         name_length;
  logic signed [31:0] number_value;
  logic [7:0]         var_offset;
  logic [15:0]        token_row;
  logic [15:0]        token_col;
  logic               last_of_run;
  modport source (output valid, token_kind, symbol_code, name_chars, name_length,
                  number_value, var_offset, token_row, token_col, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, symbol_code, name_chars, name_length,
                  number_value, var_offset, token_row, token_col, last_of_run,
                  output ready);
endinterface

// ===== src/csl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 31
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/c_subset_lexer_top.sv =====
// Top level of the C subset lexer: sequencer, lexer state, variable table search.
// Depends on csl_pkg, csl_if (interfaces), csl_ram and assert_macros.svh.
//
//  channel   dir  payload                                            accepted when
//  in_ch     in   source_char, end_of_source                          valid && ready
//  out_ch    out  token_kind .. token_col, last_of_run                valid && ready
//
// An item is taken, checked and evaluated; its tokens then leave one per cycle
// while out_ch is ready. Ending a variable name searches the variable table RAM:
// a read state then a compare state per entry, up to the number of entries used.
// Reset is synchronous; the table holds no reset and needs no clearing pass.
// A stalled token holds in the output queue; no new item is taken meanwhile.
`include "assert_macros.svh"
module c_subset_lexer_top #(
  parameter int MAX_NAME_CHARS = csl_pkg::MAX_NAME_CHARS_DEF,
  parameter int MAX_VARIABLES  = csl_pkg::MAX_VARIABLES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  csl_in_if.sink     in_ch,
  csl_out_if.source  out_ch
);
  import csl_pkg::*;

  localparam int AW = MAX_VARIABLES > 1 ? $clog2(MAX_VARIABLES) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_CHK, ST_SRD, ST_SCMP, ST_PROC, ST_OUT} seq_t;
  typedef enum logic [3:0] {
    LM_IDLE, LM_IDENT, LM_NUMBER, LM_SLASH, LM_OP1, LM_OP2,
    LM_LINE, LM_BLOCK, LM_BSTAR, LM_ERROR, LM_DONE
  } lex_mode_t;

  seq_t              st_r, st_nxt;
  lex_mode_t         mode_r, mode_nxt;
  logic [15:0]       pend_r, pend_nxt;
  logic [63:0]       nbuf_r, nbuf_nxt;
  logic [3:0]        ncnt_r, ncnt_nxt;
  logic [31:0]       nacc_r, nacc_nxt;
  logic [15:0]       row_r, row_nxt;
  logic [15:0]       col_r, col_nxt;
  logic [31:0]       spos_r, spos_nxt;
  logic [VCNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [VCNT_W-1:0] sidx_r, sidx_nxt;
  logic              found_r, found_nxt;
  logic [VCNT_W-1:0] fidx_r, fidx_nxt;
  logic [7:0]        c_r, c_nxt;
  logic              eos_r, eos_nxt;
  tok_t              q_r [3];
  tok_t              q_nxt [3];
  logic [1:0]        qn_r, qn_nxt;
  logic [1:0]        qrd_r, qrd_nxt;

  // evaluation results, loaded when the sequencer is in ST_PROC
  lex_mode_t   p_mode;
  logic [15:0] p_pend, p_row, p_col;
  logic [63:0] p_nbuf;
  logic [3:0]  p_ncnt;
  logic [31:0] p_nacc, p_spos;
  logic [VCNT_W-1:0] p_vcnt;
  tok_t        p_q [3];
  logic [1:0]  p_n;
  logic        p_we;

  logic [63:0] rd_data;
  logic        kw_hit, too_long, paren, need_search;
  logic [2:0]  kw_idx;
  tok_t        fin_tok;
  logic        fin_err, fin_new;
  logic        in_fire, out_fire, out_last;

  csl_ram #(.WIDTH(64), .DEPTH(MAX_VARIABLES)) u_vars (
    .clk   (clk),
    .we    (st_r == ST_PROC && p_we),
    .waddr (vcnt_r[AW-1:0]),
    .wdata (nbuf_r),
    .raddr (sidx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // identifier classification
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!kw_hit && ncnt_r <= 4'd8 && nbuf_r == KW_WORDS[i]) begin
        kw_hit = 1'b1;
        kw_idx = 3'(i);
      end
    end
    too_long    = ncnt_r > 4'(MAX_NAME_CHARS);
    paren       = !eos_r && c_r == "(";
    need_search = mode_r == LM_IDENT && (eos_r || !is_ident(c_r)) &&
                  !kw_hit && !too_long && !paren;
    fin_err = 1'b0;
    fin_new = 1'b0;
    if (kw_hit) begin
      fin_tok = mk_tok(KIND_KEYWORD, SYM_KW_BASE + 5'(kw_idx), 64'd0, 4'd0, 32'd0, 8'd0,
                       spos_r);
    end else if (too_long) begin
      fin_tok = mk_tok(KIND_ERROR, SYM_NONE, 64'd0, 4'd0, 32'd0, 8'd0, spos_r);
      fin_err = 1'b1;
    end else if (paren) begin
      fin_tok = mk_tok(KIND_FUNC, SYM_NONE, nbuf_r, ncnt_r, 32'd0, 8'd0, spos_r);
    end else if (found_r) begin
      fin_tok = mk_tok(KIND_VAR, SYM_NONE, nbuf_r, ncnt_r, 32'd0,
                       {fidx_r + 5'd1, 3'b000}, spos_r);
    end else if (vcnt_r >= VCNT_W'(MAX_VARIABLES)) begin
      fin_tok = mk_tok(KIND_ERROR, SYM_NONE, 64'd0, 4'd0, 32'd0, 8'd0, spos_r);
      fin_err = 1'b1;
    end else begin
      fin_tok = mk_tok(KIND_VAR, SYM_NONE, nbuf_r, ncnt_r, 32'd0,
                       {vcnt_r + 5'd1, 3'b000}, spos_r);
      fin_new = 1'b1;
    end
  end

  // one character's worth of lexing
  always_comb begin
    logic       redo;
    logic [7:0] c, p1, p2;
    logic [3:0] ti;
    tok_t       t;
    c      = c_r;
    p1     = pend_r[7:0];
    p2     = pend_r[15:8];
    redo   = 1'b0;
    ti     = 4'd0;
    t      = '0;
    p_mode = mode_r;
    p_pend = pend_r;
    p_nbuf = nbuf_r;
    p_ncnt = ncnt_r;
    p_nacc = nacc_r;
    p_row  = row_r;
    p_col  = col_r;
    p_spos = spos_r;
    p_vcnt = vcnt_r;
    p_q    = q_r;
    p_n    = 2'd0;
    p_we   = 1'b0;
    if (eos_r) begin
      case (mode_r)
        LM_ERROR: begin
          p_q[p_n] = mk_tok(KIND_ERROR, SYM_NONE, 64'd0, 4'd0, 32'd0, 8'd0, spos_r);
          p_n = p_n + 2'd1;
        end
        LM_IDENT: begin
          p_mode = fin_err ? LM_ERROR : LM_IDLE;
          p_we   = fin_new;
          if (fin_new) p_vcnt = vcnt_r + 5'd1;
          p_q[p_n] = fin_tok;
          p_n = p_n + 2'd1;
        end
        LM_NUMBER: begin
          p_q[p_n] = mk_tok(KIND_NUM, SYM_NONE, 64'd0, 4'd0, nacc_r, 8'd0, spos_r);
          p_n = p_n + 2'd1;
        end
        LM_SLASH: begin
          p_q[p_n] = single_tok("/", spos_r);
          p_n = p_n + 2'd1;
        end
        LM_OP1: begin
          t = single_tok(p1, spos_r);
          if (t.kind == KIND_ERROR) p_mode = LM_ERROR;
          p_q[p_n] = t;
          p_n = p_n + 2'd1;
        end
        LM_OP2: begin
          ti = two_idx(p1, p2);
          p_q[p_n] = mk_tok(KIND_KEYWORD, 5'(ti[2:0]), 64'd0, 4'd0, 32'd0, 8'd0, spos_r);
          p_n = p_n + 2'd1;
        end
        LM_BLOCK, LM_BSTAR: begin
          p_mode = LM_ERROR;
          p_q[p_n] = mk_tok(KIND_ERROR, SYM_NONE, 64'd0, 4'd0, 32'd0, 8'd0, spos_r);
          p_n = p_n + 2'd1;
        end
        default: ;
      endcase
      if (p_mode != LM_ERROR) begin
        p_q[p_n] = mk_tok(KIND_END, SYM_NONE, 64'd0, 4'd0, 32'd0, 8'd0, {row_r, col_r});
        p_n = p_n + 2'd1;
        p_mode = LM_DONE;
      end
    end else if (mode_r != LM_ERROR && mode_r != LM_DONE) begin
      case (mode_r)
        LM_IDENT: begin
          if (is_ident(c)) begin
            if (ncnt_r < 4'd8) p_nbuf = nbuf_r | (64'(c) << {ncnt_r[2:0], 3'b000});
            if (ncnt_r < 4'd9) p_ncnt = ncnt_r + 4'd1;
          end else begin
            p_mode = fin_err ? LM_ERROR : LM_IDLE;
            p_we   = fin_new;
            if (fin_new) p_vcnt = vcnt_r + 5'd1;
            p_q[p_n] = fin_tok;
            p_n = p_n + 2'd1;
            redo = 1'b1;
          end
        end
        LM_NUMBER: begin
          if (is_digit(c)) begin
            p_nacc = (nacc_r << 3) + (nacc_r << 1) + 32'(c - 8'd48);
          end else begin
            p_q[p_n] = mk_tok(KIND_NUM, SYM_NONE, 64'd0, 4'd0, nacc_r, 8'd0, spos_r);
            p_n = p_n + 2'd1;
            p_mode = LM_IDLE;
            redo = 1'b1;
          end
        end
        LM_SLASH: begin
          if (c == "/") p_mode = LM_LINE;
          else if (c == "*") p_mode = LM_BLOCK;
          else begin
            p_q[p_n] = single_tok("/", spos_r);
            p_n = p_n + 2'd1;
            p_mode = LM_IDLE;
            redo = 1'b1;
          end
        end
        LM_OP1: begin
          ti = two_idx(p1, c);
          if (ti[3]) begin
            p_mode = LM_OP2;
            p_pend = {c, p1};
          end else begin
            t = single_tok(p1, spos_r);
            p_mode = (t.kind == KIND_ERROR) ? LM_ERROR : LM_IDLE;
            p_q[p_n] = t;
            p_n = p_n + 2'd1;
            redo = 1'b1;
          end
        end
        LM_OP2: begin
          p_mode = LM_IDLE;
          if (is_ident(c)) begin
            // split the pair into two single operators
            t = single_tok(p1, spos_r);
            p_q[p_n] = t;
            p_n = p_n + 2'd1;
            if (t.kind == KIND_ERROR) begin
              p_mode = LM_ERROR;
            end else begin
              t = single_tok(p2, {spos_r[31:16], spos_r[15:0] + 16'd1});
              if (t.kind == KIND_ERROR) begin
                p_mode = LM_ERROR;
                p_spos = t.pos;
              end
              p_q[p_n] = t;
              p_n = p_n + 2'd1;
            end
          end else begin
            ti = two_idx(p1, p2);
            p_q[p_n] = mk_tok(KIND_KEYWORD, 5'(ti[2:0]), 64'd0, 4'd0, 32'd0, 8'd0, spos_r);
            p_n = p_n + 2'd1;
          end
          redo = 1'b1;
        end
        LM_LINE:  if (c == "\n") p_mode = LM_IDLE;
        LM_BLOCK: if (c == "*") p_mode = LM_BSTAR;
        LM_BSTAR: begin
          if (c == "/") p_mode = LM_IDLE;
          else if (c != "*") p_mode = LM_BLOCK;
        end
        default: begin
          p_mode = LM_IDLE;
          redo = 1'b1;
        end
      endcase
      if (redo && p_mode != LM_ERROR) begin
        if (c == " " || c == "\t" || c == "\n") begin
          // blanks start nothing
        end else if (c == "{" || c == "}") begin
          p_q[p_n] = mk_tok(KIND_KEYWORD, (c == "{") ? SYM_LBRACE : SYM_RBRACE, 64'd0,
                            4'd0, 32'd0, 8'd0, {row_r, col_r});
          p_n = p_n + 2'd1;
        end else begin
          p_spos = {row_r, col_r};
          if (is_alpha(c) || c == "_") begin
            p_mode = LM_IDENT;
            p_nbuf = 64'(c);
            p_ncnt = 4'd1;
          end else if (is_digit(c)) begin
            p_mode = LM_NUMBER;
            p_nacc = 32'(c - 8'd48);
          end else if (c == "/") begin
            p_mode = LM_SLASH;
          end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&") begin
            p_mode = LM_OP1;
            p_pend = {8'd0, c};
          end else begin
            t = single_tok(c, {row_r, col_r});
            if (t.kind == KIND_ERROR) p_mode = LM_ERROR;
            p_q[p_n] = t;
            p_n = p_n + 2'd1;
          end
        end
      end
      if (c == "\n") begin
        p_row = row_r + 16'd1;
        p_col = 16'd1;
      end else begin
        p_col = col_r + 16'd1;
      end
    end
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_last = qrd_r == qn_r - 2'd1;

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    nbuf_nxt  = nbuf_r;
    ncnt_nxt  = ncnt_r;
    nacc_nxt  = nacc_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    spos_nxt  = spos_r;
    vcnt_nxt  = vcnt_r;
    sidx_nxt  = sidx_r;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    c_nxt     = c_r;
    eos_nxt   = eos_r;
    q_nxt     = q_r;
    qn_nxt    = qn_r;
    qrd_nxt   = qrd_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          c_nxt   = in_ch.source_char;
          eos_nxt = in_ch.end_of_source;
          st_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        found_nxt = 1'b0;
        sidx_nxt  = '0;
        st_nxt    = (need_search && vcnt_r != '0) ? ST_SRD : ST_PROC;
      end
      ST_SRD: st_nxt = ST_SCMP;
      ST_SCMP: begin
        if (rd_data == nbuf_r) begin
          found_nxt = 1'b1;
          fidx_nxt  = sidx_r;
          st_nxt    = ST_PROC;
        end else if (sidx_r + 5'd1 >= vcnt_r) begin
          st_nxt = ST_PROC;
        end else begin
          sidx_nxt = sidx_r + 5'd1;
          st_nxt   = ST_SRD;
        end
      end
      ST_PROC: begin
        mode_nxt = p_mode;
        pend_nxt = p_pend;
        nbuf_nxt = p_nbuf;
        ncnt_nxt = p_ncnt;
        nacc_nxt = p_nacc;
        row_nxt  = p_row;
        col_nxt  = p_col;
        spos_nxt = (p_mode == LM_ERROR && mode_r != LM_ERROR && p_n != 2'd0)
                   ? p_q[p_n - 2'd1].pos : p_spos;
        vcnt_nxt = p_vcnt;
        q_nxt    = p_q;
        qn_nxt   = p_n;
        qrd_nxt  = 2'd0;
        st_nxt   = (p_n != 2'd0) ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_fire) begin
          qrd_nxt = qrd_r + 2'd1;
          if (out_last) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      mode_r  <= LM_IDLE;
      ncnt_r  <= 4'd0;
      row_r   <= 16'd1;
      col_r   <= 16'd1;
      spos_r  <= 32'h0001_0001;
      vcnt_r  <= '0;
      found_r <= 1'b0;
      qn_r    <= 2'd0;
      qrd_r   <= 2'd0;
    end else begin
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
      ncnt_r  <= ncnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      spos_r  <= spos_nxt;
      vcnt_r  <= vcnt_nxt;
      found_r <= found_nxt;
      qn_r    <= qn_nxt;
      qrd_r   <= qrd_nxt;
    end
    pend_r <= pend_nxt;
    nbuf_r <= nbuf_nxt;
    nacc_r <= nacc_nxt;
    sidx_r <= sidx_nxt;
    fidx_r <= fidx_nxt;
    c_r    <= c_nxt;
    eos_r  <= eos_nxt;
    q_r    <= q_nxt;
  end

  assign in_ch.ready         = st_r == ST_IDLE;
  assign out_ch.valid        = st_r == ST_OUT;
  assign out_ch.token_kind   = q_r[qrd_r].kind;
  assign out_ch.symbol_code  = q_r[qrd_r].code;
  assign out_ch.name_chars   = q_r[qrd_r].name;
  assign out_ch.name_length  = q_r[qrd_r].len;
  assign out_ch.number_value = q_r[qrd_r].num;
  assign out_ch.var_offset   = q_r[qrd_r].off;
  assign out_ch.token_row    = q_r[qrd_r].pos[31:16];
  assign out_ch.token_col    = q_r[qrd_r].pos[15:0];
  assign out_ch.last_of_run  = out_last;

  `ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ch.ready && out_ch.valid)
  `ASSERT_NXT(a_last_frees, clk, rst_n, out_fire && out_last, in_ch.ready)
  `ASSERT_IMP(a_table_bound, clk, rst_n, 1'b1, vcnt_r <= VCNT_W'(MAX_VARIABLES))
  `ASSERT_IMP(a_queue_pos, clk, rst_n, out_ch.valid, qrd_r < qn_r)

endmodule
